/* design/buhr_pkg.sv */
// ----------------------------------------------------------------------------
// buhr_pkg: shared types and constants for the undo history ring
// Snapshot layout, action codes and the result record passed from the
// control core to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

package buhr_pkg;

   // action codes of a request
   typedef enum logic [2:0] {
      ACT_START     = 3'd0,
      ACT_ADD       = 3'd1,
      ACT_UNDO      = 3'd2,
      ACT_READ_LAST = 3'd3,
      ACT_READ_POS  = 3'd4
   } action_type;

   // one score snapshot, 38 bits
   typedef struct packed {
      logic [15:0] time_s;
      logic        change;
      logic        quarter;
      logic [3:0]  server;
      logic [7:0]  points_b;
      logic [7:0]  points_a;
   } entry_type;

   // memory strobes for the one history port
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   // result of one request as held in the result register
   typedef struct packed {
      logic        found;
      logic        from_mem;
      entry_type   entry;
      logic [15:0] count;
   } res_type;

   localparam logic [15:0] COUNT_MAX        = 16'hFFFF;
   localparam logic [5:0]  UNDO_LIMIT_RESET = 6'd21;

   // snapshot written by start: 0:0, server 1, change flag set, time 0
   localparam entry_type START_ENTRY = '{
      time_s:   16'd0,
      change:   1'b1,
      quarter:  1'b0,
      server:   4'd1,
      points_b: 8'd0,
      points_a: 8'd0
   };

endpackage

`default_nettype wire

/* design/buhr_hist_mem.sv */
// ----------------------------------------------------------------------------
// buhr_hist_mem: snapshot history store
// Single port ring store, one write or one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module buhr_hist_mem
   import buhr_pkg::*;
#(
   parameter int DEPTH = 32,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic        clock,
   input  wire mem_ctl_type ctl,
   input  wire logic [AW-1:0] addr,
   input  wire entry_type   wr_data,
   output entry_type        rd_data
);

   entry_type hist_mem_ff [DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         hist_mem_ff[addr] <= wr_data;
      end
   end

   // registered read, held while no read is issued
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= hist_mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/buhr_core.sv */
// ----------------------------------------------------------------------------
// buhr_core: count, undo allowance and ring pointer control
// Decodes one registered request, updates the counters and the newest-slot
// pointer, and issues the history access for it.
// ----------------------------------------------------------------------------
`default_nettype none

module buhr_core
   import buhr_pkg::*;
#(
   parameter int DEPTH = 32,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        fire,
   input  wire action_type  action,
   input  wire entry_type   entry,
   input  wire logic [7:0]  position,
   input  wire logic [5:0]  undo_limit,
   output mem_ctl_type      mem_ctl,
   output logic [AW-1:0]    mem_addr,
   output entry_type        mem_wr_data,
   output res_type          res
);

   localparam logic [5:0]    LIM_CAP  = (DEPTH < 63) ? 6'(DEPTH) : 6'd63;
   localparam logic [AW-1:0] SLOT_TOP = AW'(DEPTH - 1);
   localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
   localparam logic [15:0]   DEPTH_C  = 16'(DEPTH);

   logic [15:0]   count_ff, count_in;
   logic [5:0]    allow_ff, allow_in;
   logic [AW-1:0] ptr_ff, ptr_in;

   logic [5:0]    lim;
   logic [AW-1:0] ptr_inc, ptr_dec;
   logic [AW:0]   pos_sum;
   logic [AW-1:0] pos_slot;
   logic          pos_out;
   logic [15:0]   count_dec;
   mem_ctl_type   ctl;

   // effective ceiling of the allowance
   assign lim = (undo_limit > LIM_CAP) ? LIM_CAP : undo_limit;

   // ring pointer neighbours
   assign ptr_inc = (ptr_ff == SLOT_TOP) ? '0 : ptr_ff + 1'b1;
   assign ptr_dec = (ptr_ff == '0) ? SLOT_TOP : ptr_ff - 1'b1;

   // slot of a positional read: oldest retained is one past the newest once full
   assign pos_sum = {1'b0, ptr_inc} + {1'b0, AW'(position)};
   always_comb begin
      if (count_ff < DEPTH_C) begin
         pos_out  = ({8'd0, position} >= count_ff);
         pos_slot = AW'(position);
      end else begin
         pos_out  = ({8'd0, position} >= DEPTH_C);
         pos_slot = (pos_sum >= DEPTH_W) ? AW'(pos_sum - DEPTH_W) : AW'(pos_sum);
      end
   end

   assign count_dec = (count_ff != '0) ? count_ff - 16'd1 : count_ff;

   // request decode
   always_comb begin
      count_in     = count_ff;
      allow_in     = allow_ff;
      ptr_in       = ptr_ff;
      ctl          = '0;
      mem_addr     = ptr_ff;
      mem_wr_data  = entry;
      res.found    = 1'b0;
      res.from_mem = 1'b0;
      res.entry    = entry;
      case (action)
         ACT_START: begin
            count_in    = 16'd1;
            allow_in    = 6'd1;
            ptr_in      = '0;
            ctl.wr_en   = 1'b1;
            mem_addr    = '0;
            mem_wr_data = START_ENTRY;
            res.found   = 1'b1;
            res.entry   = START_ENTRY;
         end
         ACT_ADD: begin
            if (count_ff != COUNT_MAX) begin
               count_in  = count_ff + 16'd1;
               allow_in  = (allow_ff < lim) ? allow_ff + 6'd1 : allow_ff;
               ptr_in    = (count_ff == '0) ? '0 : ptr_inc;
               ctl.wr_en = 1'b1;
               mem_addr  = ptr_in;
               res.found = 1'b1;
            end
         end
         ACT_UNDO: begin
            if (allow_ff != '0) begin
               count_in = count_dec;
               allow_in = allow_ff - 6'd1;
               ptr_in   = (count_ff != '0) ? ptr_dec : ptr_ff;
               mem_addr = ptr_in;
               if (allow_ff != 6'd1 && count_dec != '0) begin
                  ctl.rd_en    = 1'b1;
                  res.found    = 1'b1;
                  res.from_mem = 1'b1;
               end
            end
         end
         ACT_READ_LAST: begin
            if (allow_ff != '0 && count_ff != '0) begin
               ctl.rd_en    = 1'b1;
               res.found    = 1'b1;
               res.from_mem = 1'b1;
            end
         end
         ACT_READ_POS: begin
            mem_addr = pos_slot;
            if (!pos_out) begin
               ctl.rd_en    = 1'b1;
               res.found    = 1'b1;
               res.from_mem = 1'b1;
            end
         end
         default: begin
         end
      endcase
      res.count = count_in;
   end

   assign mem_ctl.wr_en = fire & ctl.wr_en;
   assign mem_ctl.rd_en = fire & ctl.rd_en;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         allow_ff <= '0;
         ptr_ff   <= '0;
      end else if (fire) begin
         count_ff <= count_in;
         allow_ff <= allow_in;
         ptr_ff   <= ptr_in;
      end
   end

   // allowance only reaches snapshots that were counted
   a_allow_le_count: assert property (@(posedge clock) disable iff (reset)
      {10'd0, allow_ff} <= count_ff)
      else $error("undo allowance exceeds snapshot count");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= SLOT_TOP)
      else $error("ring pointer out of range");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.wr_en && mem_ctl.rd_en))
      else $error("history read and write in the same cycle");

   // a start always leaves one snapshot in slot zero
   a_start_state: assert property (@(posedge clock) disable iff (reset)
      fire && action == ACT_START |=> count_ff == 16'd1 && allow_ff == 6'd1 && ptr_ff == '0)
      else $error("start did not reset the history state");

endmodule

`default_nettype wire

/* design/bounded_undo_history_ring_unit.sv */
// ----------------------------------------------------------------------------
// bounded_undo_history_ring_unit: score snapshot ring with bounded undo
// Top level: request register, control core, history store, result register.
// ----------------------------------------------------------------------------
// Use:
//   Requests enter on req_* (valid/stall) and give exactly one response each
//   on rsp_*. Actions: start, add snapshot, undo, read newest, read by
//   position. csr_wr_en/csr_wr_data load the undo limit; write it while idle.
// Path: the request register feeds the history access and the result register;
//   the response is driven from the result register, so it becomes valid once
//   its request has moved on from the request register.
// Throughput: one request per cycle while rsp_stall is low. Each request needs
//   at most one single-port store access; counters update in the same cycle.
// Reset: synchronous; empties the history (count and allowance zero) and loads
//   an undo limit of 21. No clearing pass: the store is not initialised.
// Stall: while rsp_stall is high the response is held; one further request
//   can wait in the request register, after which req_stall is raised.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_undo_history_ring_unit
   import buhr_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_action,
   input  wire logic [7:0]  req_points_a,
   input  wire logic [7:0]  req_points_b,
   input  wire logic [3:0]  req_server,
   input  wire logic        req_quarter,
   input  wire logic        req_change,
   input  wire logic [15:0] req_time_s,
   input  wire logic [7:0]  req_position,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_found,
   output logic [7:0]       rsp_points_a_out,
   output logic [7:0]       rsp_points_b_out,
   output logic [3:0]       rsp_server_out,
   output logic             rsp_quarter_out,
   output logic             rsp_change_out,
   output logic [15:0]      rsp_time_out,
   output logic [15:0]      rsp_stored_count,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [5:0]  csr_wr_data
);

   localparam int AW = $clog2(DEPTH);

   logic        s1_valid_ff;
   action_type  s1_action_ff;
   entry_type   s1_entry_ff;
   logic [7:0]  s1_pos_ff;
   logic        s2_valid_ff;
   res_type     s2_res_ff;
   logic [5:0]  limit_ff;

   logic          advance;
   logic          req_take;
   mem_ctl_type   mem_ctl;
   logic [AW-1:0] mem_addr;
   entry_type     mem_wr_data;
   entry_type     mem_rd_data;
   res_type       core_res;
   entry_type     rsp_entry;

   // handshake
   assign advance   = s1_valid_ff && (!s2_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // undo limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= UNDO_LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff         <= action_type'(req_action);
         s1_entry_ff.points_a <= req_points_a;
         s1_entry_ff.points_b <= req_points_b;
         s1_entry_ff.server   <= req_server;
         s1_entry_ff.quarter  <= req_quarter;
         s1_entry_ff.change   <= req_change;
         s1_entry_ff.time_s   <= req_time_s;
         s1_pos_ff            <= req_position;
      end
   end

   buhr_core #(.DEPTH(DEPTH)) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .action      (s1_action_ff),
      .entry       (s1_entry_ff),
      .position    (s1_pos_ff),
      .undo_limit  (limit_ff),
      .mem_ctl     (mem_ctl),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .res         (core_res)
   );

   buhr_hist_mem #(.DEPTH(DEPTH)) u_hist (
      .clock   (clock),
      .ctl     (mem_ctl),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_res_ff <= core_res;
      end
   end

   // response snapshot fields, zero on a failed request
   always_comb begin
      if (!s2_res_ff.found) begin
         rsp_entry = '0;
      end else if (s2_res_ff.from_mem) begin
         rsp_entry = mem_rd_data;
      end else begin
         rsp_entry = s2_res_ff.entry;
      end
   end

   assign rsp_valid        = s2_valid_ff;
   assign rsp_found        = s2_res_ff.found;
   assign rsp_points_a_out = rsp_entry.points_a;
   assign rsp_points_b_out = rsp_entry.points_b;
   assign rsp_server_out   = rsp_entry.server;
   assign rsp_quarter_out  = rsp_entry.quarter;
   assign rsp_change_out   = rsp_entry.change;
   assign rsp_time_out     = rsp_entry.time_s;
   assign rsp_stored_count = s2_res_ff.count;

   // a history read always belongs to a successful request
   a_mem_found: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_res_ff.from_mem |-> s2_res_ff.found)
      else $error("history read flagged on a failed request");

   // requests are only held back when both registers are occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff && rsp_stall)
      else $error("request stalled with room in the pipeline");

   // a stalled response keeps its read data
   a_rd_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && rsp_stall |=> $stable(mem_rd_data))
      else $error("history read data changed under a stalled response");

endmodule

`default_nettype wire

/* tb/score_history_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// score_history_checker: response checker for the undo history ring
// Watches the request, response and register ports of the ring. It keeps its
// own copy of the snapshot history, the snapshot counter, the undo credit and
// the undo limit. Every response is compared, field by field and in request
// order, with the reply predicted for its request.
// ----------------------------------------------------------------------------
module score_history_checker
   import buhr_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_points_a,
   input  logic [7:0]  req_points_b,
   input  logic [3:0]  req_server,
   input  logic        req_quarter,
   input  logic        req_change,
   input  logic [15:0] req_time_s,
   input  logic [7:0]  req_position,
   // response channel
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_found,
   input  logic [7:0]  rsp_points_a_out,
   input  logic [7:0]  rsp_points_b_out,
   input  logic [3:0]  rsp_server_out,
   input  logic        rsp_quarter_out,
   input  logic        rsp_change_out,
   input  logic [15:0] rsp_time_out,
   input  logic [15:0] rsp_stored_count,
   // register port
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data,
   // status for the stimulus side
   output int          mismatch_total,
   output int          outstanding
);

   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic        found;
      entry_type   snap;
      logic [15:0] count;
   } snapshot_reply_type;

   entry_type          ring_copy [DEPTH];
   logic [15:0]        snap_count;
   logic [5:0]         undo_credit;
   logic [5:0]         undo_ceiling;
   snapshot_reply_type awaited_replies [$];
   int                 failures = 0;

   // slot of the newest snapshot for the current count
   function automatic int newest_slot();
      return (int'(snap_count) - 1) % DEPTH;
   endfunction

   // apply one request to the local state and return the reply it should give
   function automatic snapshot_reply_type predict_reply(input logic [2:0] act,
                                                        input entry_type incoming,
                                                        input logic [7:0] pos);
      snapshot_reply_type r;
      int ceiling;
      int window;
      ceiling = (int'(undo_ceiling) > DEPTH) ? DEPTH : int'(undo_ceiling);
      window  = (int'(snap_count) < DEPTH) ? int'(snap_count) : DEPTH;
      r.found = 1'b0;
      r.snap  = '0;
      case (act)
         ACT_START: begin
            ring_copy[0] = START_ENTRY;
            snap_count   = 16'd1;
            undo_credit  = 6'd1;
            r.found      = 1'b1;
            r.snap       = START_ENTRY;
         end
         ACT_ADD: begin
            // refused once the counter is saturated
            if (snap_count != COUNT_MAX) begin
               snap_count = snap_count + 16'd1;
               if (int'(undo_credit) < ceiling)
                  undo_credit = undo_credit + 6'd1;
               ring_copy[newest_slot()] = incoming;
               r.found = 1'b1;
               r.snap  = incoming;
            end
         end
         ACT_UNDO: begin
            if (undo_credit != 6'd0) begin
               if (snap_count != 16'd0)
                  snap_count = snap_count - 16'd1;
               undo_credit = undo_credit - 6'd1;
               // dropping the last reachable snapshot leaves nothing to return
               if (undo_credit != 6'd0 && snap_count != 16'd0) begin
                  r.found = 1'b1;
                  r.snap  = ring_copy[newest_slot()];
               end
            end
         end
         ACT_READ_LAST: begin
            if (undo_credit != 6'd0 && snap_count != 16'd0) begin
               r.found = 1'b1;
               r.snap  = ring_copy[newest_slot()];
            end
         end
         ACT_READ_POS: begin
            // only the retained window can be read
            if (int'(pos) < window) begin
               r.found = 1'b1;
               r.snap  = ring_copy[(int'(snap_count) - window + int'(pos)) % DEPTH];
            end
         end
         default: ;
      endcase
      r.count = snap_count;
      return r;
   endfunction

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT)
         $display("%0t: %s", $realtime, msg);
   endtask

   // monitor: register writes, responses, then new requests
   always @(posedge clock) begin
      snapshot_reply_type want;
      entry_type          incoming;
      if (reset) begin
         foreach (ring_copy[i])
            ring_copy[i] = '0;
         snap_count   = 16'd0;
         undo_credit  = 6'd0;
         undo_ceiling = UNDO_LIMIT_RESET;
         awaited_replies.delete();
      end else begin
         if (csr_wr_en)
            undo_ceiling = csr_wr_data;

         if ($isunknown(rsp_valid)) begin
            note_failure("response valid is unknown");
         end else if (rsp_valid && !rsp_stall) begin
            if (awaited_replies.size() == 0) begin
               note_failure("response with no request waiting");
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_found        !== want.found         ||
                   rsp_points_a_out !== want.snap.points_a ||
                   rsp_points_b_out !== want.snap.points_b ||
                   rsp_server_out   !== want.snap.server   ||
                   rsp_quarter_out  !== want.snap.quarter  ||
                   rsp_change_out   !== want.snap.change   ||
                   rsp_time_out     !== want.snap.time_s   ||
                   rsp_stored_count !== want.count)
                  note_failure($sformatf({"mismatch: expected found=%0d a=%0d b=%0d ",
                     "srv=%0d q=%0d c=%0d t=%0d n=%0d, got found=%0d a=%0d b=%0d ",
                     "srv=%0d q=%0d c=%0d t=%0d n=%0d"},
                     want.found, want.snap.points_a, want.snap.points_b,
                     want.snap.server, want.snap.quarter, want.snap.change,
                     want.snap.time_s, want.count,
                     rsp_found, rsp_points_a_out, rsp_points_b_out, rsp_server_out,
                     rsp_quarter_out, rsp_change_out, rsp_time_out, rsp_stored_count));
            end
         end

         if (req_valid && !req_stall) begin
            incoming.points_a = req_points_a;
            incoming.points_b = req_points_b;
            incoming.server   = req_server;
            incoming.quarter  = req_quarter;
            incoming.change   = req_change;
            incoming.time_s   = req_time_s;
            awaited_replies.push_back(predict_reply(req_action, incoming, req_position));
         end
      end
      mismatch_total <= failures;
      outstanding    <= awaited_replies.size();
   end

endmodule

/* tb/bounded_undo_history_ring_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_undo_history_ring_unit_test: testbench for the undo history ring
// Drives a directed list of corner requests, then bursts of random requests
// under several undo limits and idling patterns. Checking is done by
// score_history_checker.
// ----------------------------------------------------------------------------
module bounded_undo_history_ring_unit_test;
   import buhr_pkg::*;

   localparam int          RING_DEPTH   = 32;
   localparam int          HALF_PERIOD  = 4;
   localparam int          RESET_CYCLES = 6;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          PHASE_ITEMS  = 160;
   localparam int          CYCLE_LIMIT  = 100000;
   localparam logic [2:0]  ACT_SPARE_LO = 3'd5;
   localparam logic [2:0]  ACT_SPARE_HI = 3'd7;
   localparam logic [5:0]  LIMIT_MIN    = 6'd1;
   localparam logic [5:0]  LIMIT_MAX    = 6'd32;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action   = ACT_START;
   logic [7:0]  req_points_a = '0;
   logic [7:0]  req_points_b = '0;
   logic [3:0]  req_server   = '0;
   logic        req_quarter  = 1'b0;
   logic        req_change   = 1'b0;
   logic [15:0] req_time_s   = '0;
   logic [7:0]  req_position = '0;
   logic        rsp_valid;
   logic        rsp_stall    = 1'b0;
   logic        rsp_found;
   logic [7:0]  rsp_points_a_out;
   logic [7:0]  rsp_points_b_out;
   logic [3:0]  rsp_server_out;
   logic        rsp_quarter_out;
   logic        rsp_change_out;
   logic [15:0] rsp_time_out;
   logic [15:0] rsp_stored_count;
   logic        csr_wr_en    = 1'b0;
   logic [5:0]  csr_wr_data  = '0;

   int mismatch_total;
   int outstanding;
   int idle_pct  = 0;
   int stall_pct = 0;
   int watchdog_cycles;

   always #HALF_PERIOD clock = ~clock;

   bounded_undo_history_ring_unit #(.DEPTH(RING_DEPTH)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_points_a     (req_points_a),
      .req_points_b     (req_points_b),
      .req_server       (req_server),
      .req_quarter      (req_quarter),
      .req_change       (req_change),
      .req_time_s       (req_time_s),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_points_a_out (rsp_points_a_out),
      .rsp_points_b_out (rsp_points_b_out),
      .rsp_server_out   (rsp_server_out),
      .rsp_quarter_out  (rsp_quarter_out),
      .rsp_change_out   (rsp_change_out),
      .rsp_time_out     (rsp_time_out),
      .rsp_stored_count (rsp_stored_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   score_history_checker #(.DEPTH(RING_DEPTH)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_points_a     (req_points_a),
      .req_points_b     (req_points_b),
      .req_server       (req_server),
      .req_quarter      (req_quarter),
      .req_change       (req_change),
      .req_time_s       (req_time_s),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_points_a_out (rsp_points_a_out),
      .rsp_points_b_out (rsp_points_b_out),
      .rsp_server_out   (rsp_server_out),
      .rsp_quarter_out  (rsp_quarter_out),
      .rsp_change_out   (rsp_change_out),
      .rsp_time_out     (rsp_time_out),
      .rsp_stored_count (rsp_stored_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .mismatch_total   (mismatch_total),
      .outstanding      (outstanding)
   );

   // random back-pressure on the response side
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   function automatic entry_type random_snapshot();
      logic [63:0] raw;
      entry_type   s;
      raw = {$urandom, $urandom};
      s   = raw[37:0];
      return s;
   endfunction

   // present one request, with random idle cycles ahead of it
   task automatic send_request(input logic [2:0] act, input entry_type snap,
                               input logic [7:0] pos);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_points_a <= snap.points_a;
      req_points_b <= snap.points_b;
      req_server   <= snap.server;
      req_quarter  <= snap.quarter;
      req_change   <= snap.change;
      req_time_s   <= snap.time_s;
      req_position <= pos;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // wait until every response has come back and the block is quiet
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_undo_limit(input logic [5:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // bursts of adds and undos so that the credit reaches its ceiling and back
   task automatic random_traffic(input int n_items);
      int sent;
      int kind;
      int run;
      logic [7:0] pos;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(0, 99);
         if (kind < 5) begin
            send_request(ACT_START, random_snapshot(), 8'($urandom));
            sent++;
         end else if (kind < 35) begin
            run = $urandom_range(1, 40);
            if (run > n_items - sent)
               run = n_items - sent;
            repeat (run) send_request(ACT_ADD, random_snapshot(), 8'($urandom));
            sent += run;
         end else if (kind < 55) begin
            run = $urandom_range(1, 34);
            if (run > n_items - sent)
               run = n_items - sent;
            repeat (run) send_request(ACT_UNDO, random_snapshot(), 8'($urandom));
            sent += run;
         end else if (kind < 70) begin
            // mostly near the window edge, now and then anywhere
            pos = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
            send_request(ACT_READ_POS, random_snapshot(), pos);
            sent++;
         end else if (kind < 80) begin
            send_request(ACT_READ_LAST, random_snapshot(), 8'($urandom));
            sent++;
         end else if (kind < 96) begin
            send_request($urandom_range(0, 1) ? ACT_ADD : ACT_UNDO, random_snapshot(),
                         8'($urandom));
            sent++;
         end else begin
            send_request(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)),
                         random_snapshot(), 8'($urandom));
            sent++;
         end
      end
   endtask

   // run limit
   initial begin
      for (watchdog_cycles = 0; watchdog_cycles < CYCLE_LIMIT; watchdog_cycles++)
         @(posedge clock);
      $display("bounded_undo_history_ring_unit_test failed");
      $finish;
   end

   initial begin
      int         idle_plan  [4];
      int         stall_plan [4];
      logic [5:0] limit_plan [4];
      idle_plan  = '{0, 61, 0, 25};
      stall_plan = '{0, 0, 61, 25};
      limit_plan = '{LIMIT_MIN, LIMIT_MAX, 6'd31, 6'($urandom_range(2, 30))};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed corners with the reset undo limit
      send_request(ACT_UNDO, random_snapshot(), 8'd0);       // empty history
      send_request(ACT_READ_LAST, random_snapshot(), 8'd0);
      send_request(ACT_READ_POS, random_snapshot(), 8'd0);
      send_request(ACT_ADD, '1, 8'd0);                        // all fields at maximum
      send_request(ACT_READ_POS, random_snapshot(), 8'd0);
      send_request(ACT_START, random_snapshot(), 8'd0);
      send_request(ACT_READ_LAST, random_snapshot(), 8'd0);
      send_request(ACT_UNDO, random_snapshot(), 8'd0);       // drops the last snapshot
      send_request(ACT_READ_LAST, random_snapshot(), 8'd0);  // no credit left
      send_request(ACT_READ_POS, random_snapshot(), 8'd0);   // empty window
      send_request(ACT_UNDO, random_snapshot(), 8'd0);       // refused
      send_request(ACT_START, random_snapshot(), 8'd0);
      send_request(ACT_ADD, '0, 8'd0);                        // all fields at zero
      send_request(ACT_ADD, random_snapshot(), 8'd0);
      send_request(ACT_READ_POS, random_snapshot(), 8'd255);
      send_request(ACT_READ_POS, random_snapshot(), 8'd2);
      send_request(ACT_READ_POS, random_snapshot(), 8'd3);   // just outside the window
      send_request(ACT_UNDO, random_snapshot(), 8'd0);
      send_request(ACT_READ_LAST, random_snapshot(), 8'd0);
      send_request(ACT_SPARE_LO, random_snapshot(), 8'd0);
      send_request(3'd6, random_snapshot(), 8'd0);
      send_request(ACT_SPARE_HI, random_snapshot(), 8'd0);
      send_request(ACT_READ_POS, random_snapshot(), 8'd1);

      // random phases under different limits and idling patterns
      for (int phase = 0; phase < 4; phase++) begin
         drain_responses();
         idle_pct  = idle_plan[phase];
         stall_pct = stall_plan[phase];
         write_undo_limit(limit_plan[phase]);
         random_traffic(PHASE_ITEMS);
      end

      drain_responses();
      if (mismatch_total == 0)
         $display("bounded_undo_history_ring_unit_test passed");
      else
         $display("bounded_undo_history_ring_unit_test failed");
      $finish;
   end

endmodule

/* filelist.f */
design/buhr_pkg.sv
design/buhr_hist_mem.sv
design/buhr_core.sv
design/bounded_undo_history_ring_unit.sv
tb/score_history_checker.sv
tb/bounded_undo_history_ring_unit_test.sv
